>>> design/assert_macros.svh
// assertion macros used by the checker file trsmb_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication checked in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/trsmb_pkg.sv
// shared constants, table and helpers of the model matrix builder
// no dependencies
package trsmb_pkg;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TABLE_SEGS     = 32;
  localparam int SEG_BITS       = 5;

  function automatic logic [15:0] sine_entry(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;
      6'd3: v = 16'd4808;   6'd4: v = 16'd6393;   6'd5: v = 16'd7962;
      6'd6: v = 16'd9512;   6'd7: v = 16'd11039;  6'd8: v = 16'd12540;
      6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
      6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
      6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
      6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27246;
      6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
      6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357;
      6'd27: v = 16'd31786; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
      6'd30: v = 16'd32610; 6'd31: v = 16'd32729;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

>>> design/trsmb_stage.sv
// one matrix product stage: sat(sum of four rounded products), column-major
// depends on trsmb_pkg
module trsmb_stage import trsmb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  a [16],
  input  logic signed [31:0]  b [16],
  output logic signed [31:0]  o [16]
);
  function automatic logic signed [63:0] rmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    logic [63:0] mag;
    logic [63:0] rm;
    p   = x * y;
    mag = p[63] ? 64'(-p) : 64'(p);
    rm  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[63] ? -$signed(rm) : $signed(rm);
  endfunction

  logic signed [31:0] res [16];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        res[c*4+r] = sat32(rmul(a[r], b[c*4]) + rmul(a[4+r], b[c*4+1])
                           + rmul(a[8+r], b[c*4+2]) + rmul(a[12+r], b[c*4+3]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) o <= res;
  end
endmodule

>>> design/trs_model_matrix_builder_core.sv
// top level of the model matrix builder: M = T * Ry * Rx * Rz * S
// depends on trsmb_pkg and trsmb_stage
// usage:
//   input channel in_valid/in_ready carries one transform per beat
//   (translation, three binary angles, three scales).
//   output channel out_valid/out_ready carries four beats per transform,
//   one matrix column each, column_index 0..3, last_column on column 3.
//   pipeline: sine lookup, interpolation, four product stages, then a column
//   register serialized by a 2-bit counter.
//   flow: the rate is set by the four column beats of the output register;
//   in_ready is low while it holds a matrix, except when its last column is taken.
//   a stall on out_ready freezes the whole pipeline; nothing is lost.
//   reset clears all valid bits and the column counter; data is not reset.
module trs_model_matrix_builder_core import trsmb_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] trans_x,
  input  logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         column_index,
  output logic signed [31:0] elem_row0,
  output logic signed [31:0] elem_row1,
  output logic signed [31:0] elem_row2,
  output logic signed [31:0] elem_row3,
  output logic               last_column
);
  localparam int QB = ANGLE_BITS - 2;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // six lookups: sin/cos for x, y, z
  typedef struct packed {
    logic [5:0]     idx;
    logic [QB-1:0]  frac;
    logic           neg;
  } lk_t;

  function automatic lk_t split(input logic [ANGLE_BITS-1:0] p);
    lk_t l;
    logic [1:0] q;
    logic [QB:0] r;
    logic [QB+SEG_BITS:0] x;
    q = p[ANGLE_BITS-1 -: 2];
    r = {1'b0, p[QB-1:0]};
    if (q[0]) r = (QB+1)'(1 << QB) - r;
    x = (QB+SEG_BITS+1)'(r) << SEG_BITS;
    l.idx  = x[QB+SEG_BITS:QB] >= 6'(TABLE_SEGS) ? 6'(TABLE_SEGS) : x[QB+SEG_BITS:QB];
    l.frac = x[QB-1:0];
    l.neg  = q[1];
    return l;
  endfunction

  // stage valid bits; one enable freezes the pipe on stall
  logic v1, v2, v3, v4, v5, v6;
  logic hold;        // column register busy with a matrix
  logic [1:0] col;
  logic adv;
  assign adv = !hold || (out_ready && col == 2'd3);
  assign in_ready = adv;

  // stage 1: quadrant fold and table fetch
  lk_t l1 [6];
  logic [15:0] t0 [6], t1 [6];
  logic signed [31:0] tx1, ty1, tz1, sx1, sy1, sz1;
  always_ff @(posedge clk) begin
    if (adv) begin
      l1[0] <= split(ANGLE_BITS'(angle_x));
      l1[1] <= split(ANGLE_BITS'(ANGLE_BITS'(angle_x) + (ANGLE_BITS'(1) << QB)));
      l1[2] <= split(ANGLE_BITS'(angle_y));
      l1[3] <= split(ANGLE_BITS'(ANGLE_BITS'(angle_y) + (ANGLE_BITS'(1) << QB)));
      l1[4] <= split(ANGLE_BITS'(angle_z));
      l1[5] <= split(ANGLE_BITS'(ANGLE_BITS'(angle_z) + (ANGLE_BITS'(1) << QB)));
      tx1 <= trans_x; ty1 <= trans_y; tz1 <= trans_z;
      sx1 <= scale_x; sy1 <= scale_y; sz1 <= scale_z;
    end
  end
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      t0[i] = sine_entry(l1[i].idx);
      t1[i] = sine_entry(6'(l1[i].idx + 6'd1));
    end
  end

  // stage 2: interpolate and scale to fixed point
  logic signed [31:0] trig [6];
  logic signed [31:0] tx2, ty2, tz2, sx2, sy2, sz2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        logic [16+QB:0] dp;
        logic [16:0] v;
        logic [31:0] m;
        dp = (17+QB)'(t1[i] - t0[i]) * (17+QB)'(l1[i].frac);
        v = (l1[i].idx >= 6'(TABLE_SEGS)) ? 17'd32768
            : 17'(t0[i]) + 17'(dp >> QB);
        m = 32'((48'(v) << FRAC_BITS) >> 15);
        trig[i] <= l1[i].neg ? -$signed(m) : $signed(m);
      end
      tx2 <= tx1; ty2 <= ty1; tz2 <= tz1; sx2 <= sx1; sy2 <= sy1; sz2 <= sz1;
    end
  end

  // matrices: index c*4+r
  logic signed [31:0] rx [16], ry [16], rz [16], tm [16], sm [16];
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rx[i] = (i % 5 == 0) ? ONE : 32'sd0;
      ry[i] = rx[i]; rz[i] = rx[i];
    end
    rx[5] = trig[1]; rx[6] = -trig[0]; rx[9] = trig[0]; rx[10] = trig[1];
    ry[0] = trig[3]; ry[2] = trig[2]; ry[8] = -trig[2]; ry[10] = trig[3];
    rz[0] = trig[5]; rz[1] = -trig[4]; rz[4] = trig[4]; rz[5] = trig[5];
  end

  // product stages; T and S travel alongside
  logic signed [31:0] r1 [16], r2 [16], p3 [16], m4 [16];
  logic signed [31:0] rzd [16];
  logic signed [31:0] tx3, ty3, tz3, tx4, ty4, tz4;
  logic signed [31:0] sx3, sy3, sz3, sx4, sy4, sz4, sx5, sy5, sz5;
  always_ff @(posedge clk) begin
    if (adv) begin
      rzd <= rz;
      tx3 <= tx2; ty3 <= ty2; tz3 <= tz2; tx4 <= tx3; ty4 <= ty3; tz4 <= tz3;
      sx3 <= sx2; sy3 <= sy2; sz3 <= sz2; sx4 <= sx3; sy4 <= sy3; sz4 <= sz3;
      sx5 <= sx4; sy5 <= sy4; sz5 <= sz4;
    end
  end
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      tm[i] = (i % 5 == 0) ? ONE : 32'sd0;
      sm[i] = tm[i];
    end
    tm[12] = tx4; tm[13] = ty4; tm[14] = tz4;
    sm[0] = sx5; sm[5] = sy5; sm[10] = sz5;
  end

  trsmb_stage #(.FRAC_BITS(FRAC_BITS)) u_s3 (.clk, .en(adv), .a(ry), .b(rx), .o(r1));
  trsmb_stage #(.FRAC_BITS(FRAC_BITS)) u_s4 (.clk, .en(adv), .a(r1), .b(rzd), .o(r2));
  trsmb_stage #(.FRAC_BITS(FRAC_BITS)) u_s5 (.clk, .en(adv), .a(tm), .b(r2), .o(p3));
  trsmb_stage #(.FRAC_BITS(FRAC_BITS)) u_s6 (.clk, .en(adv), .a(p3), .b(sm), .o(m4));

  // output column register
  logic signed [31:0] om [16];
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      hold <= 1'b0; col <= 2'd0;
    end else begin
      if (adv) begin
        v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
        hold <= v6; col <= 2'd0;
      end else if (out_ready) begin
        col <= col + 2'd1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) om <= m4;
  end

  assign out_valid    = hold;
  assign column_index = col;
  assign elem_row0    = om[{col, 2'd0}];
  assign elem_row1    = om[{col, 2'd1}];
  assign elem_row2    = om[{col, 2'd2}];
  assign elem_row3    = om[{col, 2'd3}];
  assign last_column  = (col == 2'd3);
endmodule

>>> design/trsmb_checker.sv
// port-level checks of the model matrix builder, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module trsmb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] column_index,
  input logic       last_column
);
  `CHK_IMPLY(a_last, clk, rst, out_valid, last_column == (column_index == 2'd3), "last flag mismatch")
  `CHK_NEXT(a_step, clk, rst, out_valid && out_ready && !last_column, out_valid && column_index == $past(column_index) + 2'd1, "column skipped")
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(column_index), "stalled beat changed")
endmodule

bind trs_model_matrix_builder_core trsmb_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .column_index, .last_column
);
